### src/sui_pkg.sv
// Shared types and status codes for the sorted unique insert block.
package sui_pkg;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_READ_OK   = 3'd3;
    localparam logic [2:0] ST_BEYOND    = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam int IDX_BITS   = 4;
    localparam int PORT_BITS  = 32;

    typedef struct packed {
        logic cmp;
        logic shift;
    } sui_cell_ctl_t;

endpackage

### src/sui_cell.sv
// One storage cell of the sorted chain: compare against the key and shift up.
module sui_cell
    import sui_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  logic                clk,
    input  sui_cell_ctl_t       ctl,
    input  logic                valid,
    input  logic [KEY_BITS-1:0] key,
    input  logic [KEY_BITS-1:0] left_entry,
    input  logic                left_lt,
    output logic [KEY_BITS-1:0] entry,
    output logic                lt,
    output logic                eq
);

    logic [KEY_BITS-1:0] entry_reg;
    logic [KEY_BITS-1:0] entry_next;
    logic                lt_reg;
    logic                lt_next;
    logic                eq_reg;
    logic                eq_next;

    always_comb
    begin
        entry_next = entry_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctl.cmp)
        begin
            lt_next = valid && (entry_reg < key);
            eq_next = valid && (entry_reg == key);
        end
        if (ctl.shift && !lt_reg)
        begin
            entry_next = left_lt ? key : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

### src/sorted_unique_insert_top.sv
// Top level of the sorted unique insert block: control, cell chain and result register.
// The result strobe is registered from the shift state, which follows the compare state.
// Busy covers the compare and the shift state; a new request is taken only in idle.
// The compare cycle lets every cell test its entry against the key; the shift cycle moves
// the larger entries up one cell on an insert and encodes the insert position from the boundary.
// Reset clears the count and the control state; entries stay unknown until written.
module sorted_unique_insert_top
    import sui_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic [PORT_BITS-1:0] key_value,
    input  logic [IDX_BITS-1:0]  read_index,
    output logic                 done,
    output logic [2:0]           status,
    output logic [CNT_W-1:0]     position,
    output logic [PORT_BITS-1:0] entry_value,
    output logic [CNT_W-1:0]     entry_count
);

    localparam int RD_SPAN = (CAPACITY < (1 << IDX_BITS)) ? CAPACITY : (1 << IDX_BITS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    logic                  done_reg;
    logic                  done_next;
    logic [2:0]            status_reg;
    logic [2:0]            status_next;
    logic [CNT_W-1:0]      position_reg;
    logic [CNT_W-1:0]      position_next;
    logic [PORT_BITS-1:0]  entry_value_reg;
    logic [PORT_BITS-1:0]  entry_value_next;
    logic [CNT_W-1:0]      entry_count_reg;
    logic [CNT_W-1:0]      entry_count_next;

    sui_cell_ctl_t         cell_ctl;
    logic [KEY_BITS-1:0]   cell_entry [CAPACITY];
    logic [KEY_BITS-1:0]   cell_left  [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   left_lt;
    logic [CAPACITY-1:0]   bnd;

    logic                  accept;
    logic                  dup;
    logic                  full;
    logic                  idx_ok;
    logic                  do_insert;
    logic [CNT_W-1:0]      pos_enc;
    logic [KEY_BITS-1:0]   rd_val;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_lt[g]   = 1'b1;
                assign cell_left[g] = '0;
            end
            else
            begin : g_rest
                assign left_lt[g]   = cell_lt[g-1];
                assign cell_left[g] = cell_entry[g-1];
            end

            assign cell_valid[g] = (32'(g) < 32'(count_reg));
            assign bnd[g]        = !cell_lt[g] && left_lt[g];

            sui_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .valid      (cell_valid[g]),
                .key        (key_reg),
                .left_entry (cell_left[g]),
                .left_lt    (left_lt[g]),
                .entry      (cell_entry[g]),
                .lt         (cell_lt[g]),
                .eq         (cell_eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bnd[i])
            begin
                pos_enc = pos_enc | CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < RD_SPAN; i++)
        begin
            if (idx_reg == IDX_BITS'(i))
            begin
                rd_val = cell_entry[i];
            end
        end
    end

    assign dup       = |cell_eq;
    assign full      = (32'(count_reg) == 32'(CAPACITY));
    assign idx_ok    = (32'(idx_reg) < 32'(count_reg));
    assign do_insert = (state_reg == S_SHIFT) && (op_reg == OP_INSERT) && !dup && !full;

    assign cell_ctl.cmp   = (state_reg == S_CMP);
    assign cell_ctl.shift = do_insert;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        position_next    = position_reg;
        entry_value_next = entry_value_reg;
        entry_count_next = entry_count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                state_next       = S_IDLE;
                done_next        = 1'b1;
                entry_value_next = '0;
                if (op_reg == OP_READ)
                begin
                    if (idx_ok)
                    begin
                        status_next      = ST_READ_OK;
                        position_next    = CNT_W'(idx_reg);
                        entry_value_next = PORT_BITS'(rd_val);
                    end
                    else
                    begin
                        status_next   = ST_BEYOND;
                        position_next = '0;
                    end
                end
                else if (dup)
                begin
                    status_next   = ST_DUPLICATE;
                    position_next = pos_enc;
                end
                else if (full)
                begin
                    status_next   = ST_FULL;
                    position_next = CNT_W'(CAPACITY);
                end
                else
                begin
                    status_next   = ST_INSERTED;
                    position_next = pos_enc;
                    count_next    = count_reg + CNT_W'(1);
                end
                entry_count_next = (do_insert) ? count_reg + CNT_W'(1) : count_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= KEY_BITS'(key_value);
            idx_reg <= read_index;
        end
        status_reg      <= status_next;
        position_reg    <= position_next;
        entry_value_reg <= entry_value_next;
        entry_count_reg <= entry_count_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_value = entry_value_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("stored count beyond capacity");

    a_done_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_SHIFT))
        else $error("result strobe without a shift cycle");

    a_lt_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ((cell_lt & ~left_lt) == '0))
        else $error("compare flags not ordered along the chain");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken without going busy");

endmodule

### tb/sui_checker.sv
// Checker for the sorted unique insert block: predicts each request and compares its result.
`timescale 1ns / 1ps

module sui_checker
    import sui_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 operation,
    input  logic [PORT_BITS-1:0] key_value,
    input  logic [IDX_BITS-1:0]  read_index,
    input  logic                 done,
    input  logic [2:0]           status,
    input  logic [CNT_W-1:0]     position,
    input  logic [PORT_BITS-1:0] entry_value,
    input  logic [CNT_W-1:0]     entry_count,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [PORT_BITS-1:0] KEY_MASK = PORT_BITS'(
        (KEY_BITS >= PORT_BITS) ? {PORT_BITS{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1));

    typedef struct packed {
        logic [2:0]           status;
        logic [CNT_W-1:0]     position;
        logic [PORT_BITS-1:0] entry_value;
        logic [CNT_W-1:0]     entry_count;
    } set_result_t;

    logic [PORT_BITS-1:0] set_entries [CAPACITY];
    int                   set_count;
    set_result_t          awaited_results [$];
    set_result_t          next_result;
    int                   mismatches;

    function automatic set_result_t apply_request(input logic op,
                                                  input logic [PORT_BITS-1:0] key_in,
                                                  input logic [IDX_BITS-1:0] idx);
        set_result_t          r;
        logic [PORT_BITS-1:0] key;
        int                   slot;
        int                   j;
        r = '0;
        if (op == OP_READ) begin
            if (int'(idx) < set_count) begin
                r.status      = ST_READ_OK;
                r.position    = CNT_W'(idx);
                r.entry_value = set_entries[idx];
            end else begin
                r.status = ST_BEYOND;
            end
        end else begin
            key  = key_in & KEY_MASK;
            slot = set_count;
            for (j = 0; j < set_count; j++) begin
                if (slot == set_count && set_entries[j] >= key)
                    slot = j;
            end
            if (slot < set_count && set_entries[slot] == key) begin
                r.status   = ST_DUPLICATE;
                r.position = CNT_W'(slot);
            end else if (set_count >= CAPACITY) begin
                r.status   = ST_FULL;
                r.position = CNT_W'(CAPACITY);
            end else begin
                for (j = set_count; j > slot; j--)
                    set_entries[j] = set_entries[j-1];
                set_entries[slot] = key;
                set_count++;
                r.status   = ST_INSERTED;
                r.position = CNT_W'(slot);
            end
        end
        r.entry_count = CNT_W'(set_count);
        return r;
    endfunction

    task automatic compare_result();
        set_result_t exp_r;
        if (awaited_results.size() == 0) begin
            $error("result with no request waiting: status %0d position %0d", status, position);
            mismatches++;
        end else begin
            exp_r = awaited_results.pop_front();
            if (status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                mismatches++;
            end
            if (position !== exp_r.position) begin
                $error("position: expected %0d, actual %0d", exp_r.position, position);
                mismatches++;
            end
            if (entry_value !== exp_r.entry_value) begin
                $error("entry_value: expected %h, actual %h", exp_r.entry_value, entry_value);
                mismatches++;
            end
            if (entry_count !== exp_r.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, entry_count);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            set_count = 0;
            awaited_results.delete();
            pending <= 0;
        end else begin
            if (done === 1'b1)
                compare_result();
            if (start === 1'b1 && busy === 1'b0) begin
                next_result     = apply_request(operation, key_value, read_index);
                awaited_results = {awaited_results, next_result};
            end
            pending    <= awaited_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for the sorted unique insert block: reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import sui_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int KEY_BITS    = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int RANDOM_REQS = 1900;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 operation   = OP_INSERT;
    logic [PORT_BITS-1:0] key_value   = '0;
    logic [IDX_BITS-1:0]  read_index  = '0;
    logic                 busy;
    logic                 done;
    logic [2:0]           status;
    logic [CNT_W-1:0]     position;
    logic [PORT_BITS-1:0] entry_value;
    logic [CNT_W-1:0]     entry_count;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    logic [PORT_BITS-1:0] sent_keys [$];

    sorted_unique_insert_top #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .key_value   (key_value),
        .read_index  (read_index),
        .done        (done),
        .status      (status),
        .position    (position),
        .entry_value (entry_value),
        .entry_count (entry_count)
    );

    sui_checker #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .key_value   (key_value),
        .read_index  (read_index),
        .done        (done),
        .status      (status),
        .position    (position),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [PORT_BITS-1:0] key,
                                input logic [IDX_BITS-1:0] idx);
        start      <= 1'b1;
        operation  <= op;
        key_value  <= key;
        read_index <= idx;
        if (op == OP_INSERT)
            sent_keys = {sent_keys, key};
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [PORT_BITS-1:0] pick_key();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 45)
            return $urandom();
        else if (mode < 70 && sent_keys.size() > 0)
            return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        else if (mode < 85)
            return PORT_BITS'($urandom_range(0, 31));
        else begin
            case ($urandom_range(0, 4))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h8000_0000;
                default: return 32'h0000_0001;
            endcase
        end
    endfunction

    function automatic int pick_gap(input logic no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int   i;
        int   gap;
        logic no_gaps;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_READ,   32'hDEAD_BEEF, 4'd0);
        send_request(OP_READ,   32'h0000_0000, 4'd15);
        send_request(OP_INSERT, 32'h8000_0000, 4'd15);
        send_request(OP_INSERT, 32'h8000_0000, 4'd0);
        send_request(OP_READ,   32'hFFFF_FFFF, 4'd0);
        hold_off(2);
        send_request(OP_READ,   32'h0000_0000, 4'd1);
        send_request(OP_INSERT, 32'h0000_0000, 4'd7);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 4'd8);
        hold_off(1);
        send_request(OP_INSERT, 32'h0000_0000, 4'd0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 4'd15);
        send_request(OP_INSERT, 32'h4000_0000, 4'd3);
        send_request(OP_INSERT, 32'hC000_0000, 4'd12);
        send_request(OP_READ,   32'h1234_5678, 4'd15);
        send_request(OP_READ,   32'h8765_4321, 4'd4);
        for (i = 1; i <= 11; i++)
            send_request(OP_INSERT, 32'h1357_9BDF * i, IDX_BITS'(i));
        send_request(OP_INSERT, 32'h0000_0005, 4'd9);
        send_request(OP_INSERT, 32'h8000_0000, 4'd2);
        send_request(OP_READ,   32'hA5A5_A5A5, 4'd15);
        drain_results();

        no_gaps = 1'b0;
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (i % 400 == 399)
                drain_results();
            if ($urandom_range(0, 99) < 40)
                send_request(OP_READ, $urandom(), IDX_BITS'($urandom_range(0, 15)));
            else
                send_request(OP_INSERT, pick_key(), IDX_BITS'($urandom_range(0, 15)));
            gap = pick_gap(no_gaps);
            if (gap > 0)
                hold_off(gap);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
